// ----- hw/rtl/rqt_pkg.sv -----
package rqt_pkg;

    localparam int PENDING_SLOTS = 16;
    localparam int PEER_SLOTS    = 8;
    localparam int SLOT_W        = $clog2(PENDING_SLOTS);
    localparam int PEER_W        = $clog2(PEER_SLOTS);
    localparam int VOTER_W       = $clog2(PEER_SLOTS + 2);
    localparam int VOTES_W       = 4;

    localparam logic [VOTES_W-1:0] VOTES_MAX = '1;

    typedef enum logic [1:0] {
        OP_REQ = 2'd0,
        OP_RSP = 2'd1,
        OP_ACK = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        KIND_LOCAL = 2'd0,
        KIND_RESP  = 2'd1,
        KIND_HB    = 2'd2,
        KIND_FATAL = 2'd3
    } t_kind;

    localparam logic [1:0] CFG_SELF_ID      = 2'd0;
    localparam logic [1:0] CFG_PEER_COUNT   = 2'd1;
    localparam logic [1:0] CFG_LEARNER_MASK = 2'd2;
    localparam logic [1:0] CFG_SELF_VOTER   = 2'd3;

    typedef struct packed {
        t_op          op;
        logic [15:0]  from_node;
        logic [31:0]  msg_seq;
        logic [47:0]  msg_index;
        logic         reject;
        logic [31:0]  msg_term;
        logic [2:0]   peer_slot;
        logic         is_leader;
        logic [31:0]  node_term;
        logic [47:0]  commit_idx;
        logic         commit_in_term;
        logic [15:0]  known_leader;
    } t_in_item;

    typedef struct packed {
        t_kind        kind;
        logic [15:0]  dest_node;
        logic [31:0]  term;
        logic [31:0]  seq;
        logic [47:0]  log_index;
        logic         last;
    } t_out_item;

    typedef struct packed {
        logic [15:0]  self_id;
        logic [3:0]   peer_count;
        logic [7:0]   learner_mask;
        logic         self_voter;
    } t_cfg;

    // classified command handed from the front to the back
    typedef struct packed {
        t_op          op;
        logic [15:0]  from_node;
        logic [31:0]  seq;
        logic [47:0]  msg_index;
        logic [31:0]  cur_term;
        logic [47:0]  commit_idx;
        logic [2:0]   peer_slot;
    } t_cmd;

    function automatic logic f_learner(t_cfg c, logic [PEER_W-1:0] p);
        return (32'(p) < 8) && c.learner_mask[p];
    endfunction

    function automatic logic [VOTER_W-1:0] f_voters(t_cfg c);
        logic [VOTER_W-1:0] n;
        n = VOTER_W'(c.self_voter);
        for (int i = 0; i < PEER_SLOTS; i++) begin
            if ((i < 32'(c.peer_count)) && !f_learner(c, PEER_W'(i))) begin
                n = n + VOTER_W'(1);
            end
        end
        return n;
    endfunction

endpackage

// ----- hw/rtl/rqt_ifs.sv -----
interface rqt_req_if import rqt_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rqt_res_if import rqt_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rqt_cfg_if ();
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/rqt_front.sv -----
module rqt_front import rqt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg_regs,
    rqt_req_if.sink     i_req,
    output logic        o_cmd_valid,
    input  logic        i_cmd_ready,
    output t_cmd        o_cmd
);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       keep;
    logic       push;
    logic       pop;
    t_cmd       cmd_in;

    assign i_req.ready = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        case (i_req.data.op)
            OP_REQ:  keep = i_req.data.is_leader && i_cfg_regs.self_voter &&
                            i_req.data.commit_in_term;
            OP_RSP:  keep = !i_req.data.reject &&
                            (i_req.data.from_node == i_req.data.known_leader) &&
                            (i_req.data.msg_term == i_req.data.node_term);
            OP_ACK:  keep = i_req.data.is_leader &&
                            (32'(i_req.data.peer_slot) < PEER_SLOTS);
            default: keep = 1'b0;
        endcase
    end

    always_comb begin
        cmd_in.op         = i_req.data.op;
        cmd_in.from_node  = i_req.data.from_node;
        cmd_in.seq        = i_req.data.msg_seq;
        cmd_in.msg_index  = i_req.data.msg_index;
        cmd_in.cur_term   = i_req.data.node_term;
        cmd_in.commit_idx = i_req.data.commit_idx;
        cmd_in.peer_slot  = i_req.data.peer_slot;
    end

    // drop filtered items at the transfer
    assign push = i_req.valid && i_req.ready && keep;
    assign pop  = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wp] <= cmd_in;
                r_wp      <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

// ----- hw/rtl/rqt_back.sv -----
module rqt_back import rqt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg_regs,
    input  logic        i_cmd_valid,
    output logic        o_cmd_ready,
    input  t_cmd        i_cmd,
    rqt_res_if.source   o_res
);

    typedef enum logic [1:0] {S_IDLE, S_RSP, S_ACK, S_FLUSH} t_state;

    t_state              r_state;
    t_cmd                r_cmd;
    logic [SLOT_W-1:0]   r_idx;
    logic [31:0]         r_mark;
    logic [31:0]         r_ctr;
    logic [31:0]         r_ack_seq [PEER_SLOTS];
    logic                r_active  [PENDING_SLOTS];
    logic [31:0]         r_sseq    [PENDING_SLOTS];
    logic [31:0]         r_client  [PENDING_SLOTS];
    logic [47:0]         r_sidx    [PENDING_SLOTS];
    logic [15:0]         r_origin  [PENDING_SLOTS];
    logic [VOTES_W-1:0]  r_votes   [PENDING_SLOTS];
    logic [PEER_SLOTS-1:0] r_acked [PENDING_SLOTS];
    logic                r_hold_v;
    t_out_item           r_hold;
    logic                r_out_v;
    t_out_item           r_out;

    logic                found_free;
    logic [SLOT_W-1:0]   free_idx;
    logic [VOTER_W-1:0]  nvoters;
    logic [VOTER_W:0]    quorum;
    logic [15:0]         req_origin;
    logic [PEER_W-1:0]   pslot;
    logic [31:0]         new_mark;
    logic                ack_hit;
    logic [VOTES_W-1:0]  new_votes;
    logic                ack_done;
    logic                rsp_hit;
    logic                can_push;
    logic                out_load;
    logic                last_idx;
    t_out_item           req_done;
    t_out_item           ack_res;
    t_out_item           fatal_res;
    t_out_item           hb_res;
    t_out_item           rsp_res;

    function automatic t_out_item f_done(logic [15:0] origin, logic [15:0] self_id,
                                         logic [31:0] term, logic [31:0] client,
                                         logic [47:0] idx);
        t_out_item r;
        r.seq       = client;
        r.log_index = idx;
        r.last      = 1'b0;
        if (origin == self_id) begin
            r.kind      = KIND_LOCAL;
            r.dest_node = '0;
            r.term      = '0;
        end else begin
            r.kind      = KIND_RESP;
            r.dest_node = origin;
            r.term      = term;
        end
        return r;
    endfunction

    function automatic t_out_item f_with_last(t_out_item r, logic l);
        t_out_item o;
        o      = r;
        o.last = l;
        return o;
    endfunction

    always_comb begin
        found_free = 1'b0;
        free_idx   = '0;
        for (int s = PENDING_SLOTS - 1; s >= 0; s--) begin
            if (!r_active[s]) begin
                found_free = 1'b1;
                free_idx   = SLOT_W'(s);
            end
        end
    end

    assign nvoters    = f_voters(i_cfg_regs);
    assign quorum     = (VOTER_W+1)'(nvoters >> 1) + (VOTER_W+1)'(1);
    assign req_origin = (i_cmd.from_node != 16'd0) ? i_cmd.from_node : i_cfg_regs.self_id;
    assign pslot      = i_cmd.peer_slot[PEER_W-1:0];
    assign new_mark   = (i_cmd.seq > r_ack_seq[pslot]) ? i_cmd.seq : r_ack_seq[pslot];
    assign req_done   = f_done(req_origin, i_cfg_regs.self_id, i_cmd.cur_term,
                               i_cmd.seq, i_cmd.commit_idx);

    assign ack_hit   = r_active[r_idx] && !r_acked[r_idx][r_cmd.peer_slot[PEER_W-1:0]] &&
                       (r_mark >= r_sseq[r_idx]);
    assign new_votes = (!f_learner(i_cfg_regs, r_cmd.peer_slot[PEER_W-1:0]) &&
                        (r_votes[r_idx] != VOTES_MAX)) ?
                       r_votes[r_idx] + VOTES_W'(1) : r_votes[r_idx];
    assign ack_done  = ack_hit && ((VOTER_W+1 > VOTES_W) ?
                       ((VOTER_W+1)'(new_votes) >= quorum) :
                       (new_votes >= VOTES_W'(quorum)));
    assign ack_res   = f_done(r_origin[r_idx], i_cfg_regs.self_id, r_cmd.cur_term,
                              r_client[r_idx], r_sidx[r_idx]);
    assign rsp_hit   = r_active[r_idx] && (r_client[r_idx] == r_cmd.seq);
    assign can_push  = !r_out_v || o_res.ready;
    assign last_idx  = (32'(r_idx) == PENDING_SLOTS - 1);
    assign out_load  = r_hold_v && can_push &&
                       (((r_state == S_ACK) && ack_done) || (r_state == S_FLUSH));

    always_comb begin
        fatal_res         = '0;
        fatal_res.kind    = KIND_FATAL;
        hb_res            = '0;
        hb_res.kind       = KIND_HB;
        rsp_res           = '0;
        rsp_res.kind      = KIND_LOCAL;
        rsp_res.seq       = r_cmd.seq;
        rsp_res.log_index = r_cmd.msg_index;
    end

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_res.valid = r_out_v;
    assign o_res.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ctr    <= '0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_idx    <= '0;
            for (int p = 0; p < PEER_SLOTS; p++) r_ack_seq[p] <= '0;
            for (int s = 0; s < PENDING_SLOTS; s++) r_active[s] <= 1'b0;
        end else begin
            if (r_out_v && o_res.ready && !out_load) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        r_idx <= '0;
                        case (i_cmd.op)
                            OP_REQ: begin
                                r_state <= S_FLUSH;
                                if (r_ctr == '1) begin
                                    r_hold   <= fatal_res;
                                    r_hold_v <= 1'b1;
                                end else begin
                                    r_ctr <= r_ctr + 32'd1;
                                    if (found_free) begin
                                        r_sseq[free_idx]   <= r_ctr + 32'd1;
                                        r_client[free_idx] <= i_cmd.seq;
                                        r_sidx[free_idx]   <= i_cmd.commit_idx;
                                        r_origin[free_idx] <= req_origin;
                                        r_votes[free_idx]  <= VOTES_W'(1);
                                        r_acked[free_idx]  <= '0;
                                        if (nvoters == VOTER_W'(1)) begin
                                            r_hold   <= req_done;
                                            r_hold_v <= 1'b1;
                                        end else if (nvoters > VOTER_W'(1)) begin
                                            r_active[free_idx] <= 1'b1;
                                            r_hold   <= hb_res;
                                            r_hold_v <= 1'b1;
                                        end
                                    end
                                end
                            end
                            OP_RSP: r_state <= S_RSP;
                            OP_ACK: begin
                                r_ack_seq[pslot] <= new_mark;
                                r_mark           <= new_mark;
                                r_state          <= S_ACK;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_RSP: begin
                    if (rsp_hit) begin
                        r_active[r_idx] <= 1'b0;
                        r_hold          <= rsp_res;
                        r_hold_v        <= 1'b1;
                        r_state         <= S_FLUSH;
                    end else if (last_idx) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_idx <= r_idx + SLOT_W'(1);
                    end
                end
                S_ACK: begin
                    // hold the scan while a completion has nowhere to go
                    if (!(ack_done && r_hold_v && !can_push)) begin
                        if (ack_hit) begin
                            r_acked[r_idx][r_cmd.peer_slot[PEER_W-1:0]] <= 1'b1;
                            r_votes[r_idx] <= new_votes;
                        end
                        if (ack_done) begin
                            r_active[r_idx] <= 1'b0;
                            if (r_hold_v) begin
                                r_out   <= f_with_last(r_hold, 1'b0);
                                r_out_v <= 1'b1;
                            end
                            r_hold   <= ack_res;
                            r_hold_v <= 1'b1;
                        end
                        r_idx <= r_idx + SLOT_W'(1);
                        if (last_idx) begin
                            r_state <= S_FLUSH;
                        end
                    end
                end
                S_FLUSH: begin
                    if (!r_hold_v) begin
                        r_state <= S_IDLE;
                    end else if (can_push) begin
                        r_out    <= f_with_last(r_hold, 1'b1);
                        r_out_v  <= 1'b1;
                        r_hold_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- hw/rtl/read_quorum_tracker_top.sv -----
// channel | dir | transfer when            | payload
// i_req   | in  | i_req.valid & i_req.ready | t_in_item  (request, response, ack)
// o_res   | out | o_res.valid & o_res.ready | t_out_item (one per result, last marks end)
// i_cfg   | in  | i_cfg.valid & i_cfg.ready | index, 16-bit data (always ready)
//
// A request passes from idle through the flush state of the back; a response scans one
// slot per cycle until the first match; an ack always scans all 16 slots and holds
// on an output stall. The serial slot scan in the back sets the pace.
// A two-entry queue lets the front take items while the back scans.
// Reset is synchronous and clears slot valid bits, counters and marks at once.
// The scan holds while a completion waits on a stalled output register.
module read_quorum_tracker_top import rqt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rqt_req_if.sink   i_req,
    rqt_res_if.source o_res,
    rqt_cfg_if.sink   i_cfg
);

    t_cfg  r_cfg;
    logic  cmd_valid;
    logic  cmd_ready;
    t_cmd  cmd;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.self_id      <= 16'd1;
            r_cfg.peer_count   <= 4'd0;
            r_cfg.learner_mask <= 8'd0;
            r_cfg.self_voter   <= 1'b1;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_SELF_ID:      r_cfg.self_id      <= i_cfg.data;
                CFG_PEER_COUNT:   r_cfg.peer_count   <= i_cfg.data[3:0];
                CFG_LEARNER_MASK: r_cfg.learner_mask <= i_cfg.data[7:0];
                CFG_SELF_VOTER:   r_cfg.self_voter   <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    rqt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_regs  (r_cfg),
        .i_req       (i_req),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    rqt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_regs  (r_cfg),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_res       (o_res)
    );

    a_fatal_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (o_res.data.kind == KIND_FATAL) |-> o_res.data.last)
        else $error("fatal result not marked last");

    a_hb_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (o_res.data.kind == KIND_HB) |-> o_res.data.last)
        else $error("heartbeat result not marked last");

    a_cmd_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_valid |-> (cmd.op == OP_REQ) || (cmd.op == OP_RSP) || (cmd.op == OP_ACK))
        else $error("unused op reached the back");

endmodule
